// File: hdl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/mcsl_pkg.sv
`default_nettype none

package mcsl_pkg;

    typedef enum logic [2:0] {
        FUNC_SET_REQ    = 3'd0,
        FUNC_SET_BYPASS = 3'd1,
        FUNC_SET_SLEW   = 3'd2,
        FUNC_ACTIVATE   = 3'd3,
        FUNC_DEACTIVATE = 3'd4,
        FUNC_TICK       = 3'd5
    } t_func;

    typedef struct packed {
        t_func              func;
        logic [3:0]         motor_index;
        logic signed [15:0] power;
        logic [15:0]        slew_step;
    } t_cmd;

    typedef struct packed {
        logic [3:0]         out_index;
        logic signed [15:0] drive_value;
        logic               sent;
        logic               last;
    } t_result;

    // Per-channel control that rides alongside the read data of a tick sweep.
    typedef struct packed {
        logic vld;
        logic act;
        logic last;
    } t_lane_ctl;

endpackage

`default_nettype wire

// File: hdl/mcsl_step.sv
`default_nettype none

// Two-stage slew datapath: step toward request, then clamp / truncate / emit.
module mcsl_step import mcsl_pkg::*; #(
    parameter int CHANNELS  = 10,
    parameter int MAX_DRIVE = 127,
    parameter int MIN_DRIVE = -127,
    parameter int FRAC_BITS = 8,
    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int AW = 16 + FRAC_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_lane_ctl            i_ctl,
    input  wire logic [IW-1:0]        i_idx,
    input  wire logic signed [15:0]   i_req,
    input  wire logic signed [AW-1:0] i_art,
    input  wire logic [15:0]          i_slew,
    output logic                      o_busy,
    output logic                      o_wb_en,
    output logic [IW-1:0]             o_wb_idx,
    output logic signed [AW-1:0]      o_wb_art,
    output logic                      o_res_vld,
    output t_result                   o_res
);

    localparam int EW = AW + 2;
    localparam logic signed [EW-1:0] MAX_FX =
        EW'(longint'(MAX_DRIVE) * (longint'(1) << FRAC_BITS));
    localparam logic signed [EW-1:0] MIN_FX =
        EW'(longint'(MIN_DRIVE) * (longint'(1) << FRAC_BITS));
    localparam logic signed [EW-1:0] RND = EW'((longint'(1) << FRAC_BITS) - 1);

    logic signed [EW-1:0] art_e, req_e, slew_e, sum_e, stepped;
    logic                 moving, up;

    logic                 r_w_vld, r_w_sent, r_w_last;
    logic [IW-1:0]        r_w_idx;
    logic signed [AW-1:0] r_w_art;

    logic signed [EW-1:0] w_e, clamped, rounded, drive_e;

    logic                 r_o_vld;
    t_result              r_o_res;
    t_result              n_o_res;

    // step stage
    always_comb begin
        art_e   = EW'(i_art);
        req_e   = EW'(i_req) <<< FRAC_BITS;
        slew_e  = EW'(i_slew);
        moving  = i_ctl.act && (art_e != req_e);
        up      = req_e > art_e;
        sum_e   = up ? (art_e + slew_e) : (art_e - slew_e);
        if (up) begin
            stepped = (sum_e > req_e) ? req_e : sum_e;
        end else begin
            stepped = (sum_e < req_e) ? req_e : sum_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_vld <= 1'b0;
        end else begin
            r_w_vld <= i_ctl.vld;
        end
        r_w_sent <= moving;
        r_w_last <= i_ctl.last;
        r_w_idx  <= i_idx;
        r_w_art  <= AW'(stepped);
    end

    // clamp and truncate toward zero
    always_comb begin
        w_e     = EW'(r_w_art);
        if (w_e > MAX_FX) begin
            clamped = MAX_FX;
        end else if (w_e < MIN_FX) begin
            clamped = MIN_FX;
        end else begin
            clamped = w_e;
        end
        rounded = clamped + ((clamped < 0) ? RND : '0);
        drive_e = rounded >>> FRAC_BITS;

        n_o_res.out_index   = 4'(r_w_idx);
        n_o_res.drive_value = r_w_sent ? drive_e[15:0] : 16'sd0;
        n_o_res.sent        = r_w_sent;
        n_o_res.last        = r_w_last;
    end

    assign o_wb_en  = r_w_vld && r_w_sent;
    assign o_wb_idx = r_w_idx;
    assign o_wb_art = AW'(clamped);
    assign o_busy   = r_w_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_w_vld;
        end
        r_o_res <= n_o_res;
    end

    assign o_res_vld = r_o_vld;
    assign o_res     = r_o_res;

endmodule

`default_nettype wire

// File: hdl/multi_channel_motor_slew_limiter.sv
`default_nettype none

// Multi-channel motor slew limiter. Commands arrive on i_cmd and are taken
// when start is high while busy is low. Set-request, bypass, set-slew,
// activate and deactivate each complete in the accept cycle and produce no
// result; addresses at or beyond CHANNELS and function codes 6 and 7 are
// ignored. A tick sweeps all channels, one per cycle, and emits exactly one
// result per channel in index order on consecutive cycles, each marked by
// o_strobe for one cycle, with last set on the highest channel. The receiver
// cannot stall: every strobed result must be captured on that cycle. After a
// tick is accepted busy stays high until every channel has passed the read
// issue, read-data and step registers (one read per channel through the single
// channel memory), so the next transaction can be taken once the last channel
// has left the step register. Results are registered after the clamp; the last
// one is strobed in the cycle in which busy has just dropped. No clearing pass
// is needed after reset: per-field valid bits make unwritten channels read as
// zero.
module multi_channel_motor_slew_limiter import mcsl_pkg::*; #(
    parameter int CHANNELS  = 10,
    parameter int MAX_DRIVE = 127,
    parameter int MIN_DRIVE = -127,
    parameter int FRAC_BITS = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_cmd i_cmd,
    output logic      busy,
    output logic      o_strobe,
    output t_result   o_result
);

    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW = 16 + FRAC_BITS;

    // One row per channel; fields have separate write enables.
    typedef struct packed {
        logic signed [15:0]   req;
        logic signed [AW-1:0] art;
        logic [15:0]          slew;
    } t_row;

    t_row r_mem [CHANNELS];
    t_row r_rdata;

    // per-field "written since reset" flags and the active flags
    logic [CHANNELS-1:0] r_vld_req, r_vld_art, r_vld_slew, r_active;

    // tick sweep: read issue stage
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    logic          rd_last;

    // read-data stage
    t_lane_ctl     r_c_ctl;
    logic [IW-1:0] r_c_idx;
    logic          r_c_vreq, r_c_vart, r_c_vslew;

    logic                 step_busy;
    logic                 wb_en;
    logic [IW-1:0]        wb_idx;
    logic signed [AW-1:0] wb_art;

    // command decode
    logic                 accept, cmd_in_range, cmd_ok, tick_go;
    logic [IW-1:0]        cmd_idx;
    logic signed [AW-1:0] cmd_art;

    logic                 wr_req_en, wr_art_en, wr_slew_en;
    logic [IW-1:0]        wr_idx;
    logic signed [AW-1:0] wr_art_val;

    logic signed [15:0]   c_req;
    logic signed [AW-1:0] c_art;
    logic [15:0]          c_slew;

    assign busy         = r_rd_vld || r_c_ctl.vld || step_busy;
    assign accept       = start && !busy;
    assign tick_go      = accept && (i_cmd.func == FUNC_TICK);
    assign cmd_in_range = int'(i_cmd.motor_index) < CHANNELS;
    assign cmd_ok       = accept && cmd_in_range && (i_cmd.func != FUNC_TICK);
    assign cmd_idx      = IW'(i_cmd.motor_index);
    assign cmd_art      = AW'(i_cmd.power) <<< FRAC_BITS;

    // Single write port. Tick write-back and commands never overlap since
    // commands are held off by busy for the whole sweep.
    always_comb begin
        wr_req_en  = 1'b0;
        wr_art_en  = wb_en;
        wr_slew_en = 1'b0;
        wr_idx     = wb_en ? wb_idx : cmd_idx;
        wr_art_val = wb_en ? wb_art : cmd_art;
        if (cmd_ok) begin
            case (i_cmd.func)
                FUNC_SET_REQ: begin
                    wr_req_en = 1'b1;
                end
                FUNC_SET_BYPASS: begin
                    wr_req_en = 1'b1;
                    wr_art_en = 1'b1;
                end
                FUNC_SET_SLEW: begin
                    wr_slew_en = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // channel memory: write, then registered read for the sweep
    always_ff @(posedge i_clk) begin
        if (wr_req_en) begin
            r_mem[wr_idx].req <= i_cmd.power;
        end
        if (wr_art_en) begin
            r_mem[wr_idx].art <= wr_art_val;
        end
        if (wr_slew_en) begin
            r_mem[wr_idx].slew <= i_cmd.slew_step;
        end
        if (r_rd_vld) begin
            r_rdata <= r_mem[r_rd_idx];
        end
    end

    // valid and active flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_req  <= '0;
            r_vld_art  <= '0;
            r_vld_slew <= '0;
            r_active   <= '0;
        end else begin
            if (wr_req_en) begin
                r_vld_req[wr_idx] <= 1'b1;
            end
            if (wr_art_en) begin
                r_vld_art[wr_idx] <= 1'b1;
            end
            if (wr_slew_en) begin
                r_vld_slew[wr_idx] <= 1'b1;
            end
            if (cmd_ok && (i_cmd.func == FUNC_ACTIVATE)) begin
                r_active[cmd_idx] <= 1'b1;
            end
            if (cmd_ok && (i_cmd.func == FUNC_DEACTIVATE)) begin
                r_active[cmd_idx] <= 1'b0;
            end
        end
    end

    // sweep sequencer: one channel read per cycle
    assign rd_last = r_rd_idx == IW'(CHANNELS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld    <= 1'b0;
            r_rd_idx    <= '0;
            r_c_ctl.vld <= 1'b0;
        end else begin
            if (tick_go) begin
                r_rd_vld <= 1'b1;
                r_rd_idx <= '0;
            end else if (r_rd_vld) begin
                r_rd_vld <= !rd_last;
                r_rd_idx <= rd_last ? '0 : r_rd_idx + 1'b1;
            end
            r_c_ctl.vld <= r_rd_vld;
        end
        // flags sampled with the read so they line up with r_rdata
        r_c_ctl.act  <= r_active[r_rd_idx];
        r_c_ctl.last <= rd_last;
        r_c_idx      <= r_rd_idx;
        r_c_vreq     <= r_vld_req[r_rd_idx];
        r_c_vart     <= r_vld_art[r_rd_idx];
        r_c_vslew    <= r_vld_slew[r_rd_idx];
    end

    // unwritten fields read as zero
    assign c_req  = r_c_vreq  ? r_rdata.req  : '0;
    assign c_art  = r_c_vart  ? r_rdata.art  : '0;
    assign c_slew = r_c_vslew ? r_rdata.slew : '0;

    mcsl_step #(
        .CHANNELS  (CHANNELS),
        .MAX_DRIVE (MAX_DRIVE),
        .MIN_DRIVE (MIN_DRIVE),
        .FRAC_BITS (FRAC_BITS)
    ) u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (r_c_ctl),
        .i_idx     (r_c_idx),
        .i_req     (c_req),
        .i_art     (c_art),
        .i_slew    (c_slew),
        .o_busy    (step_busy),
        .o_wb_en   (wb_en),
        .o_wb_idx  (wb_idx),
        .o_wb_art  (wb_art),
        .o_res_vld (o_strobe),
        .o_res     (o_result)
    );

    // Checks: results of a tick come as one unbroken burst closed by last.
    `include "assert_macros.svh"

    `ASSERT_NEXT(a_tick_sets_busy, i_clk, i_rst_n, tick_go, busy, "tick accepted without busy")
    `ASSERT_NEXT(a_burst_unbroken, i_clk, i_rst_n, o_strobe && !o_result.last, o_strobe, "gap in tick results")
    `ASSERT_NEXT(a_burst_ends, i_clk, i_rst_n, o_strobe && o_result.last, !o_strobe, "result after last")
    `ASSERT_SAME(a_strobe_in_tick, i_clk, i_rst_n, o_strobe, $past(busy), "result outside a tick")

endmodule

`default_nettype wire

// File: tb/multi_channel_motor_slew_limiter_tb.sv
`default_nettype none

module multi_channel_motor_slew_limiter_tb;
    import mcsl_pkg::*;

    localparam int CHANNELS     = 10;
    localparam int MAX_DRIVE    = 127;
    localparam int MIN_DRIVE    = -127;
    localparam int FRAC_BITS    = 8;
    localparam int N_RANDOM     = 195;
    localparam int CYCLE_LIMIT  = 200000;
    // Final drain wait, longer than a sweep keeps busy high.
    localparam int DRAIN_CYCLES = CHANNELS + 8;

    // Function codes the block must ignore.
    localparam t_func FUNC_UNUSED_6 = t_func'(3'd6);
    localparam t_func FUNC_UNUSED_7 = t_func'(3'd7);

    // How a directed row pins its sweep results: not at all (predictor only),
    // every channel idle, or one channel to a hand-written value.
    typedef enum logic [1:0] {
        PIN_NONE,
        PIN_ALL_IDLE,
        PIN_CHAN
    } t_pin;

    typedef struct {
        t_cmd cmd;
        t_pin pin;
        int   chan;
        int   drive;
        bit   sent;
    } t_row;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    t_cmd    i_cmd;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    // Row that travels with the command currently on i_cmd.
    t_row cur_row;

    // Shadow copy of the channel table.
    logic signed [15:0] req_speed  [CHANNELS] = '{default: '0};
    int                 art_fixed  [CHANNELS] = '{default: 0};
    logic        [15:0] slew_fixed [CHANNELS] = '{default: '0};
    bit                 chan_on    [CHANNELS] = '{default: 1'b0};

    t_result drive_results_q[$];

    int n_errors   = 0;
    int n_accepted = 0;
    int n_sweeps   = 0;
    int n_checked  = 0;
    int n_updates  = 0;
    int cycles     = 0;
    int burst_left = 0;

    multi_channel_motor_slew_limiter #(
        .CHANNELS  (CHANNELS),
        .MAX_DRIVE (MAX_DRIVE),
        .MIN_DRIVE (MIN_DRIVE),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_cmd mk_cmd(t_func f, int idx, int pwr, int stp);
        t_cmd c;
        c.func        = f;
        c.motor_index = 4'(idx);
        c.power       = 16'(pwr);
        c.slew_step   = 16'(stp);
        return c;
    endfunction

    // Update the shadow table for one accepted transaction; a tick sweep
    // queues one expected result per channel, in channel order.
    function automatic void apply_motor_cmd(t_row r);
        int      a;
        int      target;
        t_result res;
        if (r.cmd.func == FUNC_TICK) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                a      = art_fixed[ch];
                target = int'(req_speed[ch]) * (1 << FRAC_BITS);
                res             = '0;
                res.out_index   = 4'(ch);
                res.last        = (ch == CHANNELS - 1);
                if (chan_on[ch] && a != target) begin
                    if (target > a) begin
                        a = a + int'(slew_fixed[ch]);
                        if (a > target) a = target;
                    end else begin
                        a = a - int'(slew_fixed[ch]);
                        if (a < target) a = target;
                    end
                    if (a > MAX_DRIVE * (1 << FRAC_BITS)) a = MAX_DRIVE * (1 << FRAC_BITS);
                    if (a < MIN_DRIVE * (1 << FRAC_BITS)) a = MIN_DRIVE * (1 << FRAC_BITS);
                    art_fixed[ch] = a;
                    // drive value truncates toward zero, not toward -inf
                    res.drive_value = 16'((a >= 0) ? (a >>> FRAC_BITS) : -((-a) >>> FRAC_BITS));
                    res.sent        = 1'b1;
                end
                if (r.pin == PIN_ALL_IDLE) begin
                    res.drive_value = '0;
                    res.sent        = 1'b0;
                end else if (r.pin == PIN_CHAN && r.chan == ch) begin
                    res.drive_value = 16'(r.drive);
                    res.sent        = r.sent;
                end
                drive_results_q.push_back(res);
            end
        end else if (r.cmd.motor_index < CHANNELS) begin
            case (r.cmd.func)
                FUNC_SET_REQ: begin
                    req_speed[r.cmd.motor_index] = r.cmd.power;
                end
                FUNC_SET_BYPASS: begin
                    // no clamp here; the next changing tick clamps
                    req_speed[r.cmd.motor_index] = r.cmd.power;
                    art_fixed[r.cmd.motor_index] = int'(r.cmd.power) * (1 << FRAC_BITS);
                end
                FUNC_SET_SLEW: begin
                    slew_fixed[r.cmd.motor_index] = r.cmd.slew_step;
                end
                FUNC_ACTIVATE: begin
                    chan_on[r.cmd.motor_index] = 1'b1;
                end
                FUNC_DEACTIVATE: begin
                    chan_on[r.cmd.motor_index] = 1'b0;
                end
                default: begin
                end
            endcase
        end
    endfunction

    // Result checker and transaction monitor. Both sample pre-edge values.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (drive_results_q.size() == 0) begin
                    $error("result for channel %0d with none expected", o_result.out_index);
                    n_errors++;
                end else begin
                    want = drive_results_q.pop_front();
                    n_checked++;
                    if (o_result.sent) n_updates++;
                    if (o_result.out_index !== want.out_index) begin
                        $error("out_index: expected %0d, got %0d",
                               want.out_index, o_result.out_index);
                        n_errors++;
                    end
                    if (o_result.drive_value !== want.drive_value) begin
                        $error("drive_value: expected %0d, got %0d",
                               want.drive_value, o_result.drive_value);
                        n_errors++;
                    end
                    if (o_result.sent !== want.sent) begin
                        $error("sent: expected %0b, got %0b", want.sent, o_result.sent);
                        n_errors++;
                    end
                    if (o_result.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, o_result.last);
                        n_errors++;
                    end
                end
            end
            if (start && !busy) begin
                apply_motor_cmd(cur_row);
                n_accepted++;
                if (cur_row.cmd.func == FUNC_TICK) n_sweeps++;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, drive_results_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one transaction and hold it until the block takes it. The sender
    // runs in bursts; between bursts start often drops and i_cmd carries junk.
    task automatic send_cmd(t_row r);
        int   gap;
        t_cmd junk;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                junk.func        = t_func'(3'($urandom_range(0, 7)));
                junk.motor_index = 4'($urandom_range(0, 15));
                junk.power       = 16'($urandom_range(0, 65535));
                junk.slew_step   = 16'($urandom_range(0, 65535));
                start <= 1'b0;
                i_cmd <= junk;
                repeat (gap) @(posedge i_clk);
            end
            // now and then a long run with no idling at all
            burst_left = $urandom_range(0, 5) == 0 ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 10);
        end
        start   <= 1'b1;
        i_cmd   <= r.cmd;
        cur_row <= r;
        do @(posedge i_clk); while (busy);
        burst_left--;
    endtask

    // Stop sending until every queued result has come back.
    task automatic wait_results_done();
        start <= 1'b0;
        @(posedge i_clk);
        while (drive_results_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_row script[$];
        t_row row;
        int   sel;
        int   p;

        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;
        cur_row = t_row'{'0, PIN_NONE, 0, 0, 1'b0};

        // Directed table. Pinned rows have results that follow directly
        // from the spec; PIN_NONE rows rely on the predictor.
        // sweep straight after reset: everything idle
        script.push_back(t_row'{mk_cmd(FUNC_TICK, 0, 0, 0), PIN_ALL_IDLE, 0, 0, 1'b0});
        script.push_back(t_row'{mk_cmd(FUNC_ACTIVATE, 0, 0, 0), PIN_NONE, 0, 0, 1'b0});
        script.push_back(t_row'{mk_cmd(FUNC_SET_SLEW, 0, 0, 'hFFFF), PIN_NONE, 0, 0, 1'b0});
        script.push_back(t_row'{mk_cmd(FUNC_SET_REQ, 0, 32767, 0), PIN_NONE, 0, 0, 1'b0});
        // full step, clamped at the top; request out of reach so sent again
        script.push_back(t_row'{mk_cmd(FUNC_TICK, 0, 0, 0), PIN_CHAN, 0, 127, 1'b1});
        script.push_back(t_row'{mk_cmd(FUNC_TICK, 0, 0, 0), PIN_CHAN, 0, 127, 1'b1});
        script.push_back(t_row'{mk_cmd(FUNC_SET_REQ, 0, -32768, 0), PIN_NONE, 0, 0, 1'b0});
        script.push_back(t_row'{mk_cmd(FUNC_TICK, 0, 0, 0), PIN_CHAN, 0, -127, 1'b1});
        // bypass to the most negative value on an inactive channel
        script.push_back(t_row'{mk_cmd(FUNC_SET_BYPASS, 1, -32768, 0), PIN_NONE, 0, 0, 1'b0});
        script.push_back(t_row'{mk_cmd(FUNC_TICK, 0, 0, 0), PIN_CHAN, 1, 0, 1'b0});
        script.push_back(t_row'{mk_cmd(FUNC_ACTIVATE, 1, 0, 0), PIN_NONE, 0, 0, 1'b0});
        script.push_back(t_row'{mk_cmd(FUNC_SET_SLEW, 1, 0, 'h0180), PIN_NONE, 0, 0, 1'b0});
        script.push_back(t_row'{mk_cmd(FUNC_SET_REQ, 1, 0, 0), PIN_NONE, 0, 0, 1'b0});
        script.push_back(t_row'{mk_cmd(FUNC_TICK, 0, 0, 0), PIN_NONE, 0, 0, 1'b0});
        // settled channel stays quiet
        script.push_back(t_row'{mk_cmd(FUNC_SET_BYPASS, 2, 5, 0), PIN_NONE, 0, 0, 1'b0});
        script.push_back(t_row'{mk_cmd(FUNC_ACTIVATE, 2, 0, 0), PIN_NONE, 0, 0, 1'b0});
        script.push_back(t_row'{mk_cmd(FUNC_TICK, 0, 0, 0), PIN_CHAN, 2, 0, 1'b0});
        // half-unit negative step truncates toward zero
        script.push_back(t_row'{mk_cmd(FUNC_SET_SLEW, 3, 0, 'h0080), PIN_NONE, 0, 0, 1'b0});
        script.push_back(t_row'{mk_cmd(FUNC_SET_REQ, 3, -3, 0), PIN_NONE, 0, 0, 1'b0});
        script.push_back(t_row'{mk_cmd(FUNC_ACTIVATE, 3, 0, 0), PIN_NONE, 0, 0, 1'b0});
        script.push_back(t_row'{mk_cmd(FUNC_TICK, 0, 0, 0), PIN_CHAN, 3, 0, 1'b1});
        // out-of-range channels and unused codes change nothing; then channel 0 goes quiet once deactivated
        script.push_back(t_row'{mk_cmd(FUNC_ACTIVATE, 15, 0, 0), PIN_NONE, 0, 0, 1'b0});
        script.push_back(t_row'{mk_cmd(FUNC_SET_BYPASS, 10, 100, 0), PIN_NONE, 0, 0, 1'b0});
        script.push_back(t_row'{mk_cmd(FUNC_UNUSED_6, 0, 1, 1), PIN_NONE, 0, 0, 1'b0});
        script.push_back(t_row'{mk_cmd(FUNC_UNUSED_7, 1, -1, 'hFFFF), PIN_NONE, 0, 0, 1'b0});
        script.push_back(t_row'{mk_cmd(FUNC_DEACTIVATE, 0, 0, 0), PIN_NONE, 0, 0, 1'b0});
        script.push_back(t_row'{mk_cmd(FUNC_TICK, 0, 0, 0), PIN_CHAN, 0, 0, 1'b0});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) send_cmd(script[i]);
        wait_results_done();

        // Random part: mostly in-range channel updates and sweeps, with a
        // few out-of-range and unused-code transactions mixed in.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) wait_results_done();
            row.pin              = PIN_NONE;
            row.chan             = 0;
            row.drive            = 0;
            row.sent             = 1'b0;
            row.cmd.motor_index  = 4'($urandom_range(0, CHANNELS - 1));
            row.cmd.slew_step    = 16'($urandom_range(0, 65535));
            sel = $urandom_range(0, 3);
            if (sel < 2) begin
                p = int'($urandom_range(0, 300)) - 150;
            end else if (sel == 2) begin
                p = $urandom_range(120, 135);
                if ($urandom_range(0, 1)) p = -p;
            end else begin
                p = $urandom_range(0, 65535);
            end
            row.cmd.power = 16'(p);
            sel = $urandom_range(0, 99);
            if (sel < 25) begin
                row.cmd.func = FUNC_TICK;
                row.cmd.motor_index = 4'($urandom_range(0, 15));
            end else if (sel < 45) begin
                row.cmd.func = FUNC_SET_REQ;
            end else if (sel < 53) begin
                row.cmd.func = FUNC_SET_BYPASS;
            end else if (sel < 65) begin
                row.cmd.func = FUNC_SET_SLEW;
                // mostly slow slews so channels take several sweeps to settle
                if ($urandom_range(0, 3) != 0)
                    row.cmd.slew_step = 16'($urandom_range(0, 'h0400));
            end else if (sel < 80) begin
                row.cmd.func = FUNC_ACTIVATE;
            end else if (sel < 87) begin
                row.cmd.func = FUNC_DEACTIVATE;
            end else if (sel < 96) begin
                row.cmd.func = t_func'(3'($urandom_range(0, 4)));
                row.cmd.motor_index = 4'($urandom_range(CHANNELS, 15));
            end else begin
                row.cmd.func = $urandom_range(0, 1) ? FUNC_UNUSED_6 : FUNC_UNUSED_7;
            end
            send_cmd(row);
        end

        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (drive_results_q.size() != 0) begin
            $error("%0d expected results never arrived", drive_results_q.size());
            n_errors++;
        end

        $display("%0d commands taken, %0d sweeps, %0d channel results checked",
                 n_accepted, n_sweeps, n_checked);
        $display("%0d results carried a drive update, %0d mismatches",
                 n_updates, n_errors);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+hdl
hdl/mcsl_pkg.sv
hdl/mcsl_step.sv
hdl/multi_channel_motor_slew_limiter.sv
tb/multi_channel_motor_slew_limiter_tb.sv
